// File: rtl/cjr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjr_pkg
// Types, codes and arithmetic helpers shared by the jam recovery controller.
// ----------------------------------------------------------------------------
package cjr_pkg;

  localparam int VelW   = 10;
  localparam int DriveW = 15;
  localparam int ActW   = 2;
  localparam int PhaseW = 2;
  localparam int RegIdxW = 2;

  localparam int VoltPerUnit = 30;

  localparam logic signed [VelW-1:0] RUN_VELOCITY_RST   = 10'sd0;
  localparam logic signed [VelW-1:0] JAM_THRESHOLD_RST  = 10'sd350;
  localparam logic signed [VelW-1:0] REVERSE_VELOCITY_RST = -10'sd400;

  typedef enum logic [ActW-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef enum logic [PhaseW-1:0] {
    PH_NORMAL  = 2'd0,
    PH_PAUSED  = 2'd1,
    PH_REVERSE = 2'd2
  } phase_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_RUN_VELOCITY     = 2'd0,
    REG_JAM_THRESHOLD    = 2'd1,
    REG_REVERSE_VELOCITY = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [VelW-1:0] run_velocity;
    logic signed [VelW-1:0] jam_threshold_velocity;
    logic signed [VelW-1:0] reverse_velocity;
  } cfg_regs_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DriveW-1:0] drive_voltage;
    logic [PhaseW-1:0]        phase;
  } result_t;

  // divide by two, truncating toward zero
  function automatic logic signed [VelW-1:0] half_trunc(input logic signed [VelW-1:0] v);
    logic signed [VelW-1:0] biased;
    biased = v + VelW'(v[VelW-1]);
    return biased >>> 1;
  endfunction

  function automatic logic signed [DriveW-1:0] to_millivolts(
    input logic signed [VelW-1:0] v
  );
    logic signed [DriveW-1:0] wide;
    wide = DriveW'(v);
    return DriveW'(wide * DriveW'(VoltPerUnit));
  endfunction

endpackage

// File: rtl/cjr_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjr_cmd_if
// Command channel: tick, start or stop, with the measured motor speed.
// ----------------------------------------------------------------------------
interface cjr_cmd_if import cjr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ActW-1:0]        action;
  logic signed [VelW-1:0] measured_velocity;

  modport source (output valid, action, measured_velocity, input ready);
  modport sink (input valid, action, measured_velocity, output ready);
endinterface

// File: rtl/cjr_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjr_result_if
// Result channel: drive command and recovery phase for one tick.
// ----------------------------------------------------------------------------
interface cjr_result_if import cjr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive_voltage;
  logic [PhaseW-1:0]        phase;

  modport source (output valid, drive_voltage, phase, input ready);
  modport sink (input valid, drive_voltage, phase, output ready);
endinterface

// File: rtl/cjr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cjr_cfg_if import cjr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  logic [VelW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/cjr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjr_cfg_regs
// Speed and threshold settings, written over the configuration channel.
// ----------------------------------------------------------------------------
module cjr_cfg_regs import cjr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  cjr_cfg_if.sink      cfg,
  output cfg_regs_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.run_velocity           <= RUN_VELOCITY_RST;
      regs.jam_threshold_velocity <= JAM_THRESHOLD_RST;
      regs.reverse_velocity       <= REVERSE_VELOCITY_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_RUN_VELOCITY:     regs.run_velocity           <= $signed(cfg.data);
        REG_JAM_THRESHOLD:    regs.jam_threshold_velocity <= $signed(cfg.data);
        REG_REVERSE_VELOCITY: regs.reverse_velocity       <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/cjr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjr_core
// Run/stop control, jam detection and recovery sequencing for one command.
// ----------------------------------------------------------------------------
module cjr_core import cjr_pkg::*; #(
  parameter int JAM_TICKS      = 20,
  parameter int RECOVERY_TICKS = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [ActW-1:0]        action,
  input  logic signed [VelW-1:0] measured_velocity,
  input  cfg_regs_t              regs,
  output result_t                res
);

  localparam int JamW = $clog2(JAM_TICKS + 1);
  localparam int RecW = $clog2(RECOVERY_TICKS + 1);
  localparam logic [JamW-1:0] JAM_LIMIT = JamW'(JAM_TICKS);
  localparam logic [RecW-1:0] REC_LIMIT = RecW'(RECOVERY_TICKS);

  logic            running, running_next;
  logic            stop_pending, stop_pending_next;
  phase_t          phase, phase_next;
  logic [JamW-1:0] jam_count, jam_count_next;
  logic [RecW-1:0] pause_count, pause_count_next;
  logic [RecW-1:0] reverse_count, reverse_count_next;
  logic            last_recovery_paused, last_recovery_paused_next;

  logic signed [VelW+1:0] shortfall;
  logic signed [VelW+1:0] threshold;

  assign shortfall = (VelW+2)'(half_trunc(regs.run_velocity)) - (VelW+2)'(measured_velocity);
  assign threshold = (VelW+2)'(half_trunc(regs.jam_threshold_velocity));

  always_comb begin
    running_next              = running;
    stop_pending_next         = stop_pending;
    phase_next                = phase;
    jam_count_next            = jam_count;
    pause_count_next          = pause_count;
    reverse_count_next        = reverse_count;
    last_recovery_paused_next = last_recovery_paused;
    if (fire) begin
      unique case (action_t'(action))
        ACT_START: running_next = 1'b1;
        ACT_STOP:  stop_pending_next = 1'b1;
        ACT_TICK: begin
          if (stop_pending) begin
            stop_pending_next = 1'b0;
            running_next      = 1'b0;
          end else if (running) begin
            unique case (phase)
              PH_NORMAL: begin
                pause_count_next   = '0;
                reverse_count_next = '0;
                if (shortfall > threshold) begin
                  jam_count_next = jam_count + JamW'(1);
                end else begin
                  jam_count_next            = '0;
                  last_recovery_paused_next = 1'b0;
                end
                if (jam_count_next >= JAM_LIMIT) begin
                  phase_next = last_recovery_paused_next ? PH_REVERSE : PH_PAUSED;
                end
              end
              PH_PAUSED: begin
                jam_count_next   = '0;
                pause_count_next = pause_count + RecW'(1);
                if (pause_count_next >= REC_LIMIT) begin
                  pause_count_next          = '0;
                  phase_next                = PH_NORMAL;
                  last_recovery_paused_next = 1'b1;
                end
              end
              default: begin
                jam_count_next     = '0;
                reverse_count_next = reverse_count + RecW'(1);
                if (reverse_count_next >= REC_LIMIT) begin
                  reverse_count_next        = '0;
                  phase_next                = PH_NORMAL;
                  last_recovery_paused_next = 1'b0;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.valid         = 1'b0;
    res.drive_voltage = '0;
    if (fire && (action_t'(action) == ACT_TICK)) begin
      if (stop_pending) begin
        res.valid = 1'b1;
      end else if (running) begin
        res.valid = 1'b1;
        unique case (phase)
          PH_NORMAL: res.drive_voltage = to_millivolts(regs.run_velocity);
          PH_PAUSED: res.drive_voltage = '0;
          default:   res.drive_voltage = to_millivolts(regs.reverse_velocity);
        endcase
      end
    end
    res.phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running              <= 1'b0;
      stop_pending         <= 1'b0;
      phase                <= PH_NORMAL;
      jam_count            <= '0;
      pause_count          <= '0;
      reverse_count        <= '0;
      last_recovery_paused <= 1'b1;
    end else begin
      running              <= running_next;
      stop_pending         <= stop_pending_next;
      phase                <= phase_next;
      jam_count            <= jam_count_next;
      pause_count          <= pause_count_next;
      reverse_count        <= reverse_count_next;
      last_recovery_paused <= last_recovery_paused_next;
    end
  end

endmodule

// File: rtl/conveyor_jam_recovery_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conveyor_jam_recovery_controller
// Conveyor motor control with jam detection and pause/reverse recovery.
//
// Channels: cmd takes ticks, starts and stops with the measured speed; result
// returns one drive command and phase for every tick that commands the motor
// (a running tick or the tick that carries out a pending stop). Starts, stops
// and idle ticks give no transaction. cfg writes the three speed settings and
// is always ready; write it only while the block is idle.
// Path: a command sits in the input register and its result then goes to the
// output register.
// Throughput: one command per cycle while result is not held; all decision
// logic sits between the input register and the output register.
// Stall: while result is held, the output register keeps its transaction and
// the input register absorbs one more command before cmd.ready drops.
// Reset: motor halted, normal phase, counters cleared, settings at defaults.
// ----------------------------------------------------------------------------
module conveyor_jam_recovery_controller import cjr_pkg::*; #(
  parameter int JAM_TICKS      = 20,
  parameter int RECOVERY_TICKS = 25
) (
  input  logic           clk,
  input  logic           rst,
  cjr_cfg_if.sink        cfg,
  cjr_cmd_if.sink        cmd,
  cjr_result_if.source   result
);

  cfg_regs_t regs;
  result_t   res;

  logic                   cmd_valid;
  logic [ActW-1:0]        cmd_action;
  logic signed [VelW-1:0] cmd_measured;
  logic                   advance;

  cjr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign advance   = cmd_valid && (!result.valid || result.ready);
  assign cmd.ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_action   <= cmd.action;
      cmd_measured <= cmd.measured_velocity;
    end
  end

  cjr_core #(
    .JAM_TICKS      (JAM_TICKS),
    .RECOVERY_TICKS (RECOVERY_TICKS)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .fire              (advance),
    .action            (cmd_action),
    .measured_velocity (cmd_measured),
    .regs              (regs),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= res.valid;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      result.drive_voltage <= res.drive_voltage;
      result.phase         <= res.phase;
    end
  end

endmodule
